@@ hw/rtl/plle_pkg.sv @@
// Package: shared constants for the positional linked list engine.
`timescale 1ns / 1ps
package plle_pkg;
    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int CMD_W = 2;
    localparam int POS_W = 9;
    localparam int ID_W  = 16;
    localparam int KIND_W = 4;
    localparam int DATA_W = 64;
    localparam int ST_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
endpackage

@@ hw/rtl/plle_if.sv @@
// Interfaces: command request and result channels.
`timescale 1ns / 1ps
interface plle_cmd_if import plle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [ID_W-1:0]   entry_id;
    logic [KIND_W-1:0] entry_kind;
    logic [DATA_W-1:0] entry_data;
    modport source (output valid, command, position, entry_id, entry_kind, entry_data,
                    input ready);
    modport sink   (input valid, command, position, entry_id, entry_kind, entry_data,
                    output ready);
endinterface

interface plle_res_if import plle_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   found_id;
    logic [KIND_W-1:0] found_kind;
    logic [DATA_W-1:0] found_data;
    logic [POS_W-1:0]  list_length;
    modport source (output valid, status, found_id, found_kind, found_data, list_length,
                    input ready);
    modport sink   (input valid, status, found_id, found_kind, found_data, list_length,
                    output ready);
endinterface

@@ hw/rtl/positional_linked_list_engine_top.sv @@
// Positional linked list engine: sequencer over link and record memories.
// Read and update walk to the node; insert and delete at pos>0 walk to the node before it,
// each node visited via S_WALK and S_REC. Errors answer in the cycle after acceptance.
// One request at a time: a new request is taken once idle with the result register free.
// After reset a clearing pass chains the link memory as a free list;
// no request is accepted during it. Head, tail and count reset to zero, list empty.
`timescale 1ns / 1ps
module positional_linked_list_engine_top
    import plle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    plle_cmd_if.sink   i_cmd,
    plle_res_if.source o_res
);
    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = ID_W + KIND_W + DATA_WIDTH;

    typedef enum logic [7:0] {
        S_INIT  = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_WALK  = 8'b00000100,
        S_LINK  = 8'b00001000,
        S_REC   = 8'b00010000,
        S_FIN   = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_FREE  = 8'b10000000
    } t_state;

    // memories
    logic [SW-1:0] link_mem [CAPACITY];
    logic [RW-1:0] rec_mem  [CAPACITY];
    logic          link_we, rec_we;
    logic [SW-1:0] link_wa, link_ra, rec_wa, rec_ra;
    logic [SW-1:0] link_wd;
    logic [RW-1:0] rec_wd;
    logic [SW-1:0] r_link_q;
    logic [RW-1:0] r_rec_q;

    always_ff @(posedge i_clk) begin
        if (link_we) link_mem[link_wa] <= link_wd;
        r_link_q <= link_mem[link_ra];
    end
    always_ff @(posedge i_clk) begin
        if (rec_we) rec_mem[rec_wa] <= rec_wd;
        r_rec_q <= rec_mem[rec_ra];
    end

    t_state        r_state, n_state;
    logic [SW-1:0] r_head, n_head, r_tail, n_tail, r_free, n_free;
    logic [CW-1:0] r_count, n_count;
    logic [SW-1:0] r_cur, n_cur;       // slot being walked
    logic [CW-1:0] r_steps, n_steps;   // walk steps left
    logic [SW-1:0] r_prev, n_prev;
    logic [SW-1:0] r_node, n_node;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [CW-1:0] r_pos, n_pos;
    logic [RW-1:0] r_wrec, n_wrec;
    logic          r_ovalid, n_ovalid;
    logic [ST_W-1:0] r_st, n_st;
    logic [RW-1:0] r_found, n_found;
    logic [SW-1:0] r_init, n_init;

    logic [POS_W:0] pos_x;
    logic [POS_W:0] cnt_x;
    assign pos_x = {1'b0, i_cmd.position};
    assign cnt_x = (POS_W + 1)'(r_count);

    assign i_cmd.ready = (r_state == S_IDLE) && !r_ovalid;

    always_comb begin
        n_state = r_state; n_head = r_head; n_tail = r_tail; n_free = r_free;
        n_count = r_count; n_cur = r_cur; n_steps = r_steps; n_prev = r_prev;
        n_node = r_node; n_cmd = r_cmd; n_pos = r_pos; n_wrec = r_wrec;
        n_ovalid = r_ovalid; n_st = r_st; n_found = r_found; n_init = r_init;
        link_we = 1'b0; link_wa = '0; link_wd = '0; link_ra = r_cur;
        rec_we = 1'b0; rec_wa = '0; rec_wd = r_wrec; rec_ra = r_node;
        if (r_ovalid && o_res.ready) n_ovalid = 1'b0;
        case (r_state)
            // build the free chain
            S_INIT: begin
                link_we = 1'b1; link_wa = r_init;
                link_wd = (r_init == SW'(CAPACITY - 1)) ? '0 : r_init + 1'b1;
                n_init = r_init + 1'b1;
                if (r_init == SW'(CAPACITY - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cmd.valid && i_cmd.ready) begin
                    n_cmd = i_cmd.command;
                    n_pos = CW'(i_cmd.position);
                    n_wrec = {i_cmd.entry_id, i_cmd.entry_kind,
                              i_cmd.entry_data[DATA_WIDTH-1:0]};
                    n_found = '0;
                    n_cur = r_head;
                    if (i_cmd.command == CMD_INSERT) begin
                        if (pos_x > cnt_x) begin
                            n_st = ST_RANGE; n_ovalid = 1'b1;
                        end else if (cnt_x >= (POS_W + 1)'(CAPACITY)) begin
                            n_st = ST_FULL; n_ovalid = 1'b1;
                        end else begin
                            n_st = ST_OK; n_node = r_free; n_cur = r_free;
                            n_state = S_FREE;
                        end
                    end else if (pos_x >= cnt_x) begin
                        n_st = ST_RANGE; n_ovalid = 1'b1;
                    end else begin
                        n_st = ST_OK;
                        // delete walks to prev, read/update to node
                        if (i_cmd.command == CMD_DELETE) begin
                            if (i_cmd.position == '0) begin
                                n_node = r_head; n_state = S_FREE;
                            end else begin
                                n_steps = CW'(i_cmd.position) - 1'b1; n_state = S_WALK;
                            end
                        end else begin
                            n_steps = CW'(i_cmd.position); n_state = S_WALK;
                        end
                    end
                end
            end
            // read link of the free head (insert) or of the head (delete at 0)
            S_FREE: begin
                link_ra = r_node; n_state = S_LINK;
                n_steps = (r_pos == '0) ? '0 : r_pos - 1'b1;
            end
            // walk one node per S_WALK/S_REC pair; link of r_cur returned next cycle
            S_WALK: begin
                if (r_steps == '0) begin
                    n_prev = r_cur; n_state = S_LINK; n_node = r_cur;
                end else begin
                    link_ra = r_cur; n_state = S_REC;
                end
            end
            S_REC: begin
                n_cur = r_link_q; n_steps = r_steps - 1'b1; n_state = S_WALK;
            end
            // issue reads: link of prev/node and record of node; insert also writes the record
            S_LINK: begin
                link_ra = r_node; rec_ra = r_node;
                n_state = S_FIN;
                if (r_cmd == CMD_INSERT) begin
                    // r_link_q = link of free head
                    n_free = r_link_q;
                    rec_we = 1'b1; rec_wa = r_node;
                    n_count = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_head = r_node; n_tail = r_node; n_state = S_OUT;
                    end else if (r_pos == '0) begin
                        link_we = 1'b1; link_wa = r_node; link_wd = r_head;
                        n_head = r_node; n_state = S_OUT;
                    end else begin
                        n_prev = r_node; n_cur = r_head; n_state = S_WALK;
                        n_cmd = CMD_READ; n_steps = r_pos - 1'b1;
                        n_pos = '0; // marks insert-walk via r_wrec kept
                        n_init = r_node; // new slot
                        n_found = '1;
                    end
                end else if (r_cmd == CMD_DELETE && r_pos == '0) begin
                    n_head = r_link_q;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
                if (r_found == '1 && r_cmd == CMD_READ && r_pos == '0) begin
                    // insert after prev (r_node): r_link_q = link of prev
                    link_we = 1'b1; link_wa = r_init; link_wd = r_link_q;
                    n_prev = r_node; n_node = r_init; n_cmd = CMD_INSERT;
                    n_found = '0; n_state = S_OUT; n_pos = '1;
                    n_steps = '0;
                    if (r_node == r_tail) n_tail = r_init;
                    n_cur = r_link_q;
                    n_init = r_init;
                end else if (r_cmd == CMD_DELETE) begin
                    if (r_pos == '0) begin
                        // r_node removed from head
                        n_found = r_rec_q;
                        link_we = 1'b1; link_wa = r_node; link_wd = r_free;
                        n_free = r_node;
                        n_count = r_count - 1'b1;
                        if (r_count == CW'(1)) begin n_head = '0; n_tail = '0; end
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end else begin
                        // r_node = prev; r_link_q = victim
                        n_node = r_link_q; n_prev = r_node;
                        n_pos = '0; n_cmd = CMD_UPDATE; n_found = '1;
                        n_state = S_LINK;
                        n_steps = CW'(1);
                    end
                end else begin
                    n_found = r_rec_q;
                    if (r_cmd == CMD_UPDATE) begin
                        if (r_steps == CW'(1) && r_found == '1) begin
                            // delete victim: unlink it
                            n_found = r_rec_q;
                            link_we = 1'b1; link_wa = r_prev; link_wd = r_link_q;
                            if (r_node == r_tail) n_tail = r_prev;
                            n_state = S_OUT; n_cmd = CMD_DELETE; n_pos = '1;
                        end else begin
                            rec_we = 1'b1; rec_wa = r_node;
                            n_ovalid = 1'b1; n_state = S_IDLE;
                        end
                    end else begin
                        n_ovalid = 1'b1; n_state = S_IDLE;
                    end
                end
            end
            // finishing step: prev linked to the new node, or delete victim freed
            S_OUT: begin
                n_state = S_IDLE;
                if (r_cmd == CMD_INSERT && r_pos == '1) begin
                    link_we = 1'b1; link_wa = r_prev; link_wd = r_node;
                end
                if (r_cmd == CMD_DELETE && r_pos == '1) begin
                    link_we = 1'b1; link_wa = r_node; link_wd = r_free;
                    n_free = r_node;
                    n_count = r_count - 1'b1;
                    if (r_count == CW'(1)) begin n_head = '0; n_tail = '0; end
                end
                n_ovalid = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT; r_head <= '0; r_tail <= '0; r_free <= '0;
            r_count <= '0; r_ovalid <= 1'b0; r_init <= '0;
        end else begin
            r_state <= n_state; r_head <= n_head; r_tail <= n_tail; r_free <= n_free;
            r_count <= n_count; r_ovalid <= n_ovalid; r_init <= n_init;
        end
    end
    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_steps <= n_steps; r_prev <= n_prev; r_node <= n_node;
        r_cmd <= n_cmd; r_pos <= n_pos; r_wrec <= n_wrec; r_st <= n_st;
        r_found <= n_found;
    end

    assign o_res.valid       = r_ovalid;
    assign o_res.status      = r_st;
    assign o_res.found_id    = r_found[RW-1 -: ID_W];
    assign o_res.found_kind  = r_found[DATA_WIDTH +: KIND_W];
    assign o_res.found_data  = DATA_W'(r_found[DATA_WIDTH-1:0]);
    assign o_res.list_length = POS_W'(r_count);

    // result register holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !o_res.ready |=> r_ovalid) else $error("result dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !i_cmd.ready) else $error("ready while busy");
endmodule
